/* rtl/mirt_pkg.sv */
// Shared types, operation codes and defaults for the message id remap table.
// No dependencies; mirt_match and message_id_remap_table import this package.
`default_nettype none
package mirt_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_FWD  = 2'd1;
	localparam logic [1:0] OP_REV  = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [5:0]  entry_index;
		logic [31:0] processor_id;
		logic [31:0] spacecraft_id;
		logic [15:0] msg_id;
		logic [15:0] target_id;
	} mirt_req_t;

	typedef struct packed {
		logic [15:0] result_id;
		logic        drop;
		logic        matched;
	} mirt_rsp_t;

	typedef struct packed {
		logic [31:0] processor_id;
		logic [31:0] spacecraft_id;
		logic [15:0] from_id;
		logic [15:0] to_id;
	} mirt_entry_t;

	localparam int ENTRY_W = $bits(mirt_entry_t);

	// lookup key held for the length of one walk
	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] processor_id;
		logic [31:0] spacecraft_id;
		logic [15:0] msg_id;
	} mirt_key_t;

	// verdict of the compare unit on one table entry
	typedef struct packed {
		logic end_of_table;
		logic fwd_hit;
		logic rev_take;
	} mirt_cmp_t;

endpackage
`default_nettype wire

/* rtl/mirt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; width and depth come in as parameters.
`default_nettype none
module mirt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/mirt_match.sv */
// Shared compare unit: judges one table entry against the held lookup key.
// Depends on mirt_pkg for the entry, key and verdict types.
`default_nettype none
module mirt_match
	import mirt_pkg::*;
(
	input  wire mirt_entry_t  entry,
	input  wire mirt_key_t    key,
	input  wire logic         have_best,
	input  wire logic [15:0]  best_id,
	output mirt_cmp_t         verdict
);

	logic peer_eq;

	assign peer_eq = (entry.processor_id == key.processor_id) &&
	                 (entry.spacecraft_id == key.spacecraft_id);

	always_comb begin
		verdict.end_of_table = (entry.from_id == 16'h0000);
		verdict.fwd_hit = (key.operation == OP_FWD) && peer_eq &&
		                  (entry.from_id == key.msg_id);
		// take a reverse match only if it beats the best so far; ties keep the older
		verdict.rev_take = (key.operation == OP_REV) && peer_eq &&
		                   (entry.to_id == key.msg_id) &&
		                   (!have_best || (entry.from_id < best_id));
	end

endmodule
`default_nettype wire

/* rtl/message_id_remap_table.sv */
// Top level of the message id remap table: sequencer, table RAM and compare unit.
// Depends on mirt_pkg, mirt_ram and mirt_match.
//
//  channel | signals                 | dir | word
//  --------+-------------------------+-----+---------------------------------
//  req     | req_valid/req_ready/req | in  | load, forward or reverse item
//  rsp     | rsp_valid/rsp_ready/rsp | out | result_id, drop, matched
//  cfg     | cfg_we/cfg_wdata        | in  | default_send, written at once
//
// After reset a clearing pass zeroes the table, one entry a cycle; no word is
// taken meanwhile.
// A load or unused code goes through ST_DONE to the result register once it is free.
// A forward or reverse item walks the table RAM one entry a cycle through the
// shared compare unit, stopping early where the active part ends or a forward
// key hits. req_ready is low during the walk.
// A finished result waits in the output register while the next word is taken.
`default_nettype none
module message_id_remap_table
	import mirt_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire mirt_req_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output mirt_rsp_t      rsp,
	input  wire logic      cfg_we,
	input  wire logic      cfg_wdata
);

	localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int SLOT_W = (IDX_W > 6) ? IDX_W : 6;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_WALK  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	logic             dsend_q;
	logic [IDX_W-1:0] addr_q;
	logic             iss_q;
	logic             cmp_vld_s1;
	logic             last_s1;
	logic             hit_q;
	logic [15:0]      best_q;
	mirt_key_t        key_q;
	logic             rsp_valid_q;
	mirt_rsp_t        rsp_q;

	logic              accept;
	logic              load_wr;
	logic [SLOT_W-1:0] slot_ext;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ENTRY_W-1:0] ram_rdata;
	mirt_entry_t       entry;
	mirt_cmp_t         verdict;
	logic              out_free;
	mirt_rsp_t         rsp_d;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign slot_ext  = SLOT_W'(req.entry_index);
	assign load_wr   = accept && (req.operation == OP_LOAD) &&
	                   ({26'd0, req.entry_index} < 32'(TABLE_DEPTH));

	// the clearing pass reuses addr_q as its write pointer
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = load_wr;
			ram_waddr = slot_ext[IDX_W-1:0];
			ram_wdata = {req.processor_id, req.spacecraft_id, req.msg_id, req.target_id};
		end
	end

	assign ram_re = (state_q == ST_WALK) && iss_q;

	mirt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	assign entry = mirt_entry_t'(ram_rdata);

	mirt_match u_match (
		.entry     (entry),
		.key       (key_q),
		.have_best (hit_q),
		.best_id   (best_q),
		.verdict   (verdict)
	);

	assign out_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		rsp_d = '0;
		case (key_q.operation)
			OP_FWD: begin
				if (hit_q) begin
					rsp_d.result_id = best_q;
				end else if (dsend_q) begin
					rsp_d.result_id = key_q.msg_id;
				end
				rsp_d.matched = hit_q;
				rsp_d.drop    = (rsp_d.result_id == 16'h0000);
			end
			OP_REV: begin
				rsp_d.result_id = hit_q ? best_q : key_q.msg_id;
				rsp_d.matched   = hit_q;
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			dsend_q     <= 1'b0;
			addr_q      <= '0;
			iss_q       <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			last_s1     <= 1'b0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				dsend_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (addr_q == LAST_IDX) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						hit_q  <= 1'b0;
						addr_q <= '0;
						if ((req.operation == OP_FWD) || (req.operation == OP_REV)) begin
							iss_q   <= 1'b1;
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_WALK: begin
					// issue side: one read a cycle until the last slot or until the compare side ends the walk
					cmp_vld_s1 <= iss_q;
					last_s1    <= (addr_q == LAST_IDX);
					if (iss_q) begin
						if (addr_q == LAST_IDX) begin
							iss_q <= 1'b0;
						end else begin
							addr_q <= addr_q + 1'b1;
						end
					end
					// compare side: judge the word read last cycle
					if (cmp_vld_s1) begin
						if (verdict.end_of_table) begin
							state_q <= ST_DONE;
						end else if (verdict.fwd_hit) begin
							hit_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							if (verdict.rev_take) begin
								hit_q <= 1'b1;
							end
							if (last_s1) begin
								state_q <= ST_DONE;
							end
						end
						if (verdict.end_of_table || verdict.fwd_hit || last_s1) begin
							iss_q      <= 1'b0;
							cmp_vld_s1 <= 1'b0;
						end
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						addr_q      <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q.operation     <= req.operation;
			key_q.processor_id  <= req.processor_id;
			key_q.spacecraft_id <= req.spacecraft_id;
			key_q.msg_id        <= req.msg_id;
		end
		if ((state_q == ST_WALK) && cmp_vld_s1 && !verdict.end_of_table) begin
			if (verdict.fwd_hit) begin
				best_q <= entry.to_id;
			end else if (verdict.rev_take) begin
				best_q <= entry.from_id;
			end
		end
		if ((state_q == ST_DONE) && out_free) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

/* sim/message_id_remap_table_test.sv */
// Self-checking testbench for the message id remap table: directed and random words,
// checked against an in-bench model of the table. Depends on rtl/mirt_pkg.sv and
// rtl/message_id_remap_table.sv.
`default_nettype none
module message_id_remap_table_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mirt_pkg::*;

	localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int PHASE_WORDS = 235;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	mirt_req_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	mirt_rsp_t rsp;
	logic      cfg_we;
	logic      cfg_wdata;

	mirt_req_t   words_to_send[$];
	mirt_rsp_t   results_due[$];
	mirt_entry_t remap_shadow[TABLE_DEPTH];
	logic        send_default;
	mirt_rsp_t   result_head;

	int send_idle_pct;
	int rsp_stall_pct;
	int mismatch_count;
	int results_checked;
	int loads_seen, fwd_hits, fwd_misses, rev_hits, rev_misses, unused_seen;
	int unsigned cycle_count = 0;

	logic [31:0] proc_pool[4]  = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h8000_0001};
	logic [31:0] craft_pool[4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0002, 32'h7FFF_FFFE};

	message_id_remap_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Apply one accepted word to the shadow table and work out its result.
	function automatic mirt_rsp_t remap_lookup(mirt_req_t w);
		mirt_rsp_t   o;
		int          live;
		logic        found;
		logic [15:0] least_from;
		o = '0;
		found = 1'b0;
		least_from = '0;
		live = 0;
		while (live < TABLE_DEPTH && remap_shadow[live].from_id != 16'd0)
			live++;
		case (w.operation)
			OP_LOAD: begin
				remap_shadow[w.entry_index].processor_id  = w.processor_id;
				remap_shadow[w.entry_index].spacecraft_id = w.spacecraft_id;
				remap_shadow[w.entry_index].from_id       = w.msg_id;
				remap_shadow[w.entry_index].to_id         = w.target_id;
				loads_seen++;
			end
			OP_FWD: begin
				for (int i = 0; i < live; i++) begin
					if (!found && remap_shadow[i].processor_id == w.processor_id &&
							remap_shadow[i].spacecraft_id == w.spacecraft_id &&
							remap_shadow[i].from_id == w.msg_id) begin
						o.result_id = remap_shadow[i].to_id;
						found = 1'b1;
					end
				end
				if (!found && send_default)
					o.result_id = w.msg_id;
				o.drop = (o.result_id == 16'd0);
				o.matched = found;
				if (found) fwd_hits++;
				else fwd_misses++;
			end
			OP_REV: begin
				for (int i = 0; i < live; i++) begin
					if (remap_shadow[i].processor_id == w.processor_id &&
							remap_shadow[i].spacecraft_id == w.spacecraft_id &&
							remap_shadow[i].to_id == w.msg_id) begin
						if (!found || remap_shadow[i].from_id < least_from) begin
							least_from = remap_shadow[i].from_id;
							found = 1'b1;
						end
					end
				end
				o.result_id = found ? least_from : w.msg_id;
				o.matched = found;
				if (found) rev_hits++;
				else rev_misses++;
			end
			default: begin
				unused_seen++;
			end
		endcase
		return o;
	endfunction

	// Driver: present queued words, hold each until taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready)
				results_due.push_back(remap_lookup(req));
			if (!req_valid || req_ready) begin
				if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= words_to_send.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each taken result with the oldest one due.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result id %h drop %b matched %b", $time,
						rsp.result_id, rsp.drop, rsp.matched);
					mismatch_count++;
				end else begin
					result_head = results_due.pop_front();
					results_checked++;
					if (rsp.result_id !== result_head.result_id || rsp.drop !== result_head.drop ||
							rsp.matched !== result_head.matched) begin
						$display("%0t: expected id %h drop %b matched %b, got id %h drop %b matched %b",
							$time, result_head.result_id, result_head.drop, result_head.matched,
							rsp.result_id, rsp.drop, rsp.matched);
						mismatch_count++;
					end
				end
			end
			rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d results outstanding", $time, results_due.size());
			$display("message_id_remap_table_test: FAIL");
			$finish;
		end
	end

	function automatic mirt_req_t req_word(logic [1:0] op, logic [5:0] slot, logic [31:0] proc,
			logic [31:0] craft, logic [15:0] mid, logic [15:0] tgt);
		mirt_req_t w;
		w.operation = op;
		w.entry_index = slot;
		w.processor_id = proc;
		w.spacecraft_id = craft;
		w.msg_id = mid;
		w.target_id = tgt;
		return w;
	endfunction

	// Draw peers and ids from small sets so that lookups hit often.
	function automatic mirt_req_t pooled_word(logic [1:0] op, logic [5:0] slot);
		mirt_req_t w;
		w.operation = op;
		w.entry_index = slot;
		w.processor_id = proc_pool[$urandom_range(3)];
		w.spacecraft_id = craft_pool[$urandom_range(3)];
		w.msg_id = ($urandom_range(15) == 0) ? 16'hFFFF : 16'($urandom_range(12, 1));
		w.target_id = ($urandom_range(15) == 0) ? 16'hFFFF : 16'($urandom_range(6));
		if (op == OP_REV)
			w.msg_id = w.target_id;
		return w;
	endfunction

	function automatic mirt_req_t noise_word(logic [1:0] op);
		logic [127:0] raw;
		mirt_req_t    w;
		raw = {$urandom(), $urandom(), $urandom(), $urandom()};
		w = raw[$bits(mirt_req_t)-1:0];
		w.operation = op;
		return w;
	endfunction

	// Fill the low slots so that the active part reaches fill_depth, then mix.
	task automatic queue_random_phase(int total, int fill_depth);
		mirt_req_t w;
		int        roll;
		logic [1:0] op;
		for (int s = 0; s < fill_depth; s++)
			words_to_send.push_back(pooled_word(OP_LOAD, 6'(s)));
		for (int k = fill_depth; k < total; k++) begin
			roll = $urandom_range(99);
			op = (roll < 18) ? OP_LOAD : (roll < 55) ? OP_FWD : (roll < 93) ? OP_REV : OP_UNUSED;
			if (op == OP_UNUSED || $urandom_range(4) == 0) begin
				w = noise_word(op);
			end else begin
				w = pooled_word(op, 6'($urandom_range(63)));
				if (op == OP_LOAD && $urandom_range(1) == 0)
					w.entry_index = 6'($urandom_range(fill_depth > 63 ? 63 : fill_depth));
			end
			// cut the active part now and then
			if (op == OP_LOAD && $urandom_range(11) == 0)
				w.msg_id = 16'h0000;
			words_to_send.push_back(w);
		end
	endtask

	task automatic write_default_send(logic v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		send_default = v;
	endtask

	// sample away from the rising edge so that queue and valid updates have settled
	task automatic drain;
		@(negedge clk);
		while (words_to_send.size() != 0 || results_due.size() != 0 || req_valid)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		send_default = 1'b0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		for (int i = 0; i < TABLE_DEPTH; i++)
			remap_shadow[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		write_default_send(1'b0);
		// empty table, unused code, then a small table with duplicates and a stray slot
		words_to_send.push_back(req_word(OP_FWD, 6'd0, 32'hFFFF_FFFF, 32'h0, 16'd5, 16'd0));
		words_to_send.push_back(req_word(OP_REV, 6'd0, 32'h0, 32'h0, 16'hFFFF, 16'd0));
		words_to_send.push_back(req_word(OP_UNUSED, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF, 16'hFFFF));
		words_to_send.push_back(req_word(OP_LOAD, 6'd0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0001));
		words_to_send.push_back(req_word(OP_LOAD, 6'd1, 32'h0, 32'hFFFF_FFFF, 16'd7, 16'h0000));
		words_to_send.push_back(req_word(OP_LOAD, 6'd2, 32'd1, 32'd2, 16'd9, 16'h1234));
		words_to_send.push_back(req_word(OP_LOAD, 6'd3, 32'd1, 32'd2, 16'd9, 16'h5678));
		words_to_send.push_back(req_word(OP_LOAD, 6'd4, 32'd1, 32'd2, 16'd3, 16'h1234));
		words_to_send.push_back(req_word(OP_LOAD, 6'd5, 32'd1, 32'd2, 16'd3, 16'h1234));
		words_to_send.push_back(req_word(OP_LOAD, 6'd63, 32'h1234, 32'hABCD_0000, 16'd1, 16'd2));
		words_to_send.push_back(req_word(OP_FWD, 6'd0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'd0));
		words_to_send.push_back(req_word(OP_FWD, 6'd0, 32'h0, 32'hFFFF_FFFF, 16'd7, 16'd0));
		words_to_send.push_back(req_word(OP_FWD, 6'd0, 32'd1, 32'd2, 16'd9, 16'd0));
		words_to_send.push_back(req_word(OP_REV, 6'd0, 32'd1, 32'd2, 16'h1234, 16'd0));
		words_to_send.push_back(req_word(OP_REV, 6'd0, 32'd1, 32'd2, 16'h5678, 16'd0));
		words_to_send.push_back(req_word(OP_FWD, 6'd0, 32'h1234, 32'hABCD_0000, 16'd1, 16'd0));
		words_to_send.push_back(req_word(OP_FWD, 6'd0, 32'd1, 32'd2, 16'd0, 16'd0));
		drain();

		write_default_send(1'b1);
		words_to_send.push_back(req_word(OP_FWD, 6'd0, 32'd1, 32'd2, 16'h4321, 16'd0));
		words_to_send.push_back(req_word(OP_FWD, 6'd0, 32'd1, 32'd2, 16'd0, 16'd0));
		words_to_send.push_back(req_word(OP_FWD, 6'd0, 32'h0, 32'hFFFF_FFFF, 16'd7, 16'd0));
		words_to_send.push_back(req_word(OP_REV, 6'd0, 32'd1, 32'd2, 16'h0002, 16'd0));
		words_to_send.push_back(req_word(OP_LOAD, 6'd0, 32'hFFFF_FFFF, 32'h0, 16'h0000, 16'h0001));
		words_to_send.push_back(req_word(OP_FWD, 6'd0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'd0));
		drain();

		// no idling, whole table active at first
		write_default_send(1'b1);
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		queue_random_phase(PHASE_WORDS, TABLE_DEPTH);
		drain();

		write_default_send(1'b0);
		send_idle_pct = 57;
		rsp_stall_pct = 0;
		queue_random_phase(PHASE_WORDS, $urandom_range(63, 1));
		drain();

		write_default_send(1'b1);
		send_idle_pct = 0;
		rsp_stall_pct = 57;
		queue_random_phase(PHASE_WORDS, $urandom_range(63, 1));
		drain();

		write_default_send(1'b0);
		send_idle_pct = 10;
		rsp_stall_pct = 10;
		queue_random_phase(PHASE_WORDS, $urandom_range(63, 1));
		drain();

		repeat (TABLE_DEPTH + 8) @(posedge clk);
		$display("checked %0d results: %0d loads, %0d unused codes", results_checked,
			loads_seen, unused_seen);
		$display("forward %0d hit / %0d miss, reverse %0d hit / %0d miss", fwd_hits, fwd_misses,
			rev_hits, rev_misses);
		if (mismatch_count == 0 && results_due.size() == 0) begin
			$display("message_id_remap_table_test: PASS");
		end else begin
			$display("message_id_remap_table_test: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* message_id_remap_table.f */
rtl/mirt_pkg.sv
rtl/mirt_ram.sv
rtl/mirt_match.sv
rtl/message_id_remap_table.sv
sim/message_id_remap_table_test.sv
